/* hw/rtl/blpd_pkg.sv */
// Shared types and constants for the bounded list push/delete/dump unit.
// No dependencies; used by blpd_ctrl, blpd_datapath and the top level.
`timescale 1ns / 1ps

package blpd_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP        = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic capture;  // latch request fields
      logic update;   // apply push / delete to the list
      logic fetch;    // start the dump at element 0
      logic advance;  // current result taken, move to the next
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;     // current result closes the dump (also set when empty)
   } status_type;

endpackage

/* hw/rtl/blpd_ctrl.sv */
// Sequencer for the bounded list unit: idle, update, fetch, send.
// Depends on blpd_pkg for the command and status structs.
`timescale 1ns / 1ps

module blpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  blpd_pkg::status_type status,
   output blpd_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_UPD   = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/blpd_datapath.sv */
// List storage (circular buffer in a 1W1R memory), count, head and dump index.
// Depends on blpd_pkg; driven by blpd_ctrl through cmd_type.
`timescale 1ns / 1ps

module blpd_datapath #(
   parameter int DEPTH = blpd_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  blpd_pkg::cmd_type                   cmd,
   output blpd_pkg::status_type                status,
   input  logic [blpd_pkg::OP_W-1:0]           req_operation,
   input  logic signed [blpd_pkg::VALUE_W-1:0] req_value,
   input  logic [blpd_pkg::POS_W-1:0]          req_position,
   output logic signed [blpd_pkg::VALUE_W-1:0] rsp_element,
   output logic                                rsp_is_last,
   output logic                                rsp_list_empty,
   output logic                                rsp_push_dropped
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > blpd_pkg::POS_W) ? CNT_W : blpd_pkg::POS_W;

   // logical place -> physical slot: (head + place) mod DEPTH, sum < 2*DEPTH
   function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] h,
                                                  input logic [CNT_W-1:0] l);
      logic [SUM_W-1:0] s;
      s = SUM_W'(h) + SUM_W'(l);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   logic [blpd_pkg::VALUE_W-1:0] entries_ff [DEPTH];
   logic [blpd_pkg::VALUE_W-1:0] rd_data_ff;

   logic [blpd_pkg::OP_W-1:0]    op_ff;
   logic [blpd_pkg::VALUE_W-1:0] value_ff;
   logic [blpd_pkg::POS_W-1:0]   pos_ff;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PTR_W-1:0]             idx_ff, idx_in;
   logic                         del_ff, del_in;
   logic                         dropped_ff, dropped_in;

   logic                         wr_en, rd_en;
   logic [PTR_W-1:0]             wr_addr, rd_addr;
   logic [blpd_pkg::VALUE_W-1:0] wr_data;

   logic             full, empty, last, is_push, del_hit, compact;
   logic [PTR_W-1:0] head_dec;
   logic [CNT_W-1:0] idx_ext, idx_next;

   // source place for the dump: past the deleted slot, read one further on
   function automatic logic [CNT_W-1:0] src_place(input logic [CNT_W-1:0] j,
                                                  input logic d,
                                                  input logic [blpd_pkg::POS_W-1:0] p);
      logic [CNT_W-1:0] r;
      r = j;
      if (d && (CMP_W'(j) >= CMP_W'(p))) begin
         r = j + CNT_W'(1);
      end
      return r;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign idx_ext  = CNT_W'(idx_ff);
   assign idx_next = idx_ext + CNT_W'(1);
   assign last     = (idx_next == count_ff);
   assign is_push  = (op_ff == blpd_pkg::OP_PUSH_FRONT) || (op_ff == blpd_pkg::OP_PUSH_BACK);
   assign del_hit  = (op_ff == blpd_pkg::OP_DELETE) && (CMP_W'(pos_ff) < CMP_W'(count_ff));
   assign head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
   assign compact  = del_ff && !empty && (CMP_W'(idx_ff) >= CMP_W'(pos_ff));

   assign status.last  = empty || last;

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      del_in     = del_ff;
      dropped_in = dropped_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = value_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;

      if (cmd.capture) begin
         del_in     = 1'b0;
         dropped_in = 1'b0;
      end

      if (cmd.update) begin
         if (is_push && full) begin
            dropped_in = 1'b1;
         end else if (op_ff == blpd_pkg::OP_PUSH_FRONT) begin
            head_in  = head_dec;
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            count_in = count_ff + CNT_W'(1);
         end else if (op_ff == blpd_pkg::OP_PUSH_BACK) begin
            wr_en    = 1'b1;
            wr_addr  = phys_addr(head_ff, count_ff);
            count_in = count_ff + CNT_W'(1);
         end else if (del_hit) begin
            count_in = count_ff - CNT_W'(1);
            del_in   = 1'b1;
         end
      end

      if (cmd.fetch) begin
         idx_in = '0;
         if (!empty) begin
            rd_en   = 1'b1;
            rd_addr = phys_addr(head_ff, src_place('0, del_ff, pos_ff));
         end
      end

      if (cmd.advance) begin
         // delete closes the gap as the dump walks past it
         if (compact) begin
            wr_en   = 1'b1;
            wr_addr = phys_addr(head_ff, idx_ext);
            wr_data = rd_data_ff;
         end
         if (!empty && !last) begin
            idx_in  = idx_next[PTR_W-1:0];
            rd_en   = 1'b1;
            rd_addr = phys_addr(head_ff, src_place(idx_next, del_ff, pos_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         del_ff     <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         del_ff     <= del_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_element      = empty ? '0 : $signed(rd_data_ff);
   assign rsp_is_last      = status.last;
   assign rsp_list_empty   = empty;
   assign rsp_push_dropped = dropped_ff;

endmodule

/* hw/rtl/bounded_list_push_delete_dump_unit.sv */
// Bounded ordered list of up to DEPTH signed 32-bit values. Each request
// transaction pushes at the front, pushes at the back, deletes at a position
// or changes nothing; the unit then dumps the whole list front to back, one
// response transaction per element, is_last on the final one. An empty list
// gives one response with list_empty set and element zero. A push into a
// full list is dropped and flagged on every response of that request; a
// delete at or past the count changes nothing. A request passes through an
// update state (the list change), a fetch state (the first memory read) and
// a send state that gives one response per element; the next request is
// taken once the unit is back in idle. The dump walks the single-read-port
// list memory one slot per cycle while rsp_ready is high; a delete closes
// its gap during that same walk, so it costs no extra time. The list lives
// in a circular buffer so front pushes need no shifting. Depends on
// blpd_pkg, blpd_ctrl, blpd_datapath.
`timescale 1ns / 1ps

module bounded_list_push_delete_dump_unit #(
   parameter int DEPTH = blpd_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [blpd_pkg::OP_W-1:0]           req_operation,
   input  logic signed [blpd_pkg::VALUE_W-1:0] req_value,
   input  logic [blpd_pkg::POS_W-1:0]          req_position,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [blpd_pkg::VALUE_W-1:0] rsp_element,
   output logic                                rsp_is_last,
   output logic                                rsp_list_empty,
   output logic                                rsp_push_dropped
);

   blpd_pkg::cmd_type    cmd;
   blpd_pkg::status_type status;

   // sequencer: owns the handshakes, issues one command set per cycle
   blpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, pointers and response fields
   blpd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_element      (rsp_element),
      .rsp_is_last      (rsp_is_last),
      .rsp_list_empty   (rsp_list_empty),
      .rsp_push_dropped (rsp_push_dropped)
   );

   // an accepted request is followed by an update cycle, never a response
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("response or ready right after request accept");

   // the final response of a dump returns the unit to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_is_last) |=> (req_ready && !rsp_valid))
      else $error("unit not idle after last response");

   // empty list: single response, zero element, no drop (a drop implies full)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_list_empty) |->
         (rsp_is_last && (rsp_element == '0) && !rsp_push_dropped))
      else $error("bad empty-list response");

   // a dump does not end early without the last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_is_last) |=> rsp_valid)
      else $error("dump stopped before last element");

endmodule
